FILE: sv/pcgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcgs_pkg
// Shared widths, codes, configuration and control types of the packed cost
// grid store.
// ----------------------------------------------------------------------------
package pcgs_pkg;

    // field widths
    localparam int COORD_W    = 16;
    localparam int DIM_W      = 13;
    localparam int COST_W     = 2;
    localparam int OP_W       = 2;
    localparam int IDXO_W     = 12;
    localparam int STAT_W     = 2;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int LIN_W      = PROD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int CELL_BITS_DEF = 2;
    localparam int MAX_CELLS_DEF = 4096;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ       = 2'd0;
    localparam logic [OP_W-1:0] OP_SET        = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_BITS = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_READ_OUT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_WRITE_OUT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_COST = 3'd5;

    // configuration reset values
    localparam logic [COORD_W-1:0] ORIGIN_RST = 16'd0;
    localparam logic [DIM_W-1:0]   DIM_RST    = 13'd64;
    localparam logic [COST_W-1:0]  COST_RST   = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_z;
        logic [DIM_W-1:0]   grid_width;
        logic [DIM_W-1:0]   grid_height;
        logic [COST_W-1:0]  block_cost;
        logic [COST_W-1:0]  unknown_cost;
    } pcgs_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_calc;
        logic do_lookup;
        logic do_update;
        logic clr_start;
        logic clr_step;
        logic load_clr_result;
    } pcgs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_clear_all;
        logic clr_last;
        logic out_free;
    } pcgs_stat_t;

endpackage
`default_nettype wire

FILE: sv/pcgs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcgs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module pcgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: sv/pcgs_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcgs_cfg
// Configuration register file: origin, grid size and the two fixed costs.
// ----------------------------------------------------------------------------
module pcgs_cfg
    import pcgs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output pcgs_cfg_t                  cfg
);

    pcgs_cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x     <= ORIGIN_RST;
            cfg_reg.origin_z     <= ORIGIN_RST;
            cfg_reg.grid_width   <= DIM_RST;
            cfg_reg.grid_height  <= DIM_RST;
            cfg_reg.block_cost   <= COST_RST;
            cfg_reg.unknown_cost <= COST_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_data[COORD_W-1:0];
                REG_ORIGIN_Z:     cfg_reg.origin_z     <= cfg_data[COORD_W-1:0];
                REG_GRID_WIDTH:   cfg_reg.grid_width   <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT:  cfg_reg.grid_height  <= cfg_data[DIM_W-1:0];
                REG_BLOCK_COST:   cfg_reg.block_cost   <= cfg_data[COST_W-1:0];
                REG_UNKNOWN_COST: cfg_reg.unknown_cost <= cfg_data[COST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: sv/pcgs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcgs_ctrl
// Controller: sequences the reset sweep, the per-word lookup and
// read-modify-write, and the clear-all sweep.
// ----------------------------------------------------------------------------
module pcgs_ctrl
    import pcgs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  pcgs_stat_t stat,
    output pcgs_cmd_t  cmd
);

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CALC     = 3'd2;
    localparam logic [2:0] S_LOOK     = 3'd3;
    localparam logic [2:0] S_UPD      = 3'd4;
    localparam logic [2:0] S_CLR      = 3'd5;
    localparam logic [2:0] S_CLR_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (stat.item_clear_all) begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_CLR;
                    end else begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC: begin
                cmd.do_calc = 1'b1;
                state_next  = S_LOOK;
            end
            S_LOOK: begin
                cmd.do_lookup = 1'b1;
                state_next    = S_UPD;
            end
            S_UPD: begin
                if (stat.out_free) begin
                    cmd.do_update = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_CLR_DONE;
                end
            end
            S_CLR_DONE: begin
                if (stat.out_free) begin
                    cmd.load_clr_result = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register, reset starts the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/pcgs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcgs_dp
// Datapath: origin subtraction and bounds check, row multiply, linear index,
// cell store with read-modify-write, sweep counter and result register.
// ----------------------------------------------------------------------------
module pcgs_dp
    import pcgs_pkg::*;
#(
    parameter int CELL_BITS = CELL_BITS_DEF,
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  pcgs_cfg_t               cfg,
    input  pcgs_cmd_t               cmd,
    output pcgs_stat_t              stat,
    input  wire logic [OP_W-1:0]    s_operation,
    input  wire logic [COORD_W-1:0] s_coord_x,
    input  wire logic [COORD_W-1:0] s_coord_z,
    input  wire logic [COST_W-1:0]  s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COST_W-1:0]       m_cost,
    output logic [IDXO_W-1:0]       m_cell_index,
    output logic [STAT_W-1:0]       m_status
);

    localparam int IDX_W = $clog2(MAX_CELLS);
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_CELLS - 1);
    localparam logic [LIN_W-1:0] CELL_LIMIT = LIN_W'(MAX_CELLS);

    // item word
    logic [OP_W-1:0]    op_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cz_reg;
    logic [COST_W-1:0]  val_reg;

    // calc stage
    logic [DIM_W-1:0]   x_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               xz_in_reg;

    // lookup stage
    logic               inside_reg;
    logic [IDX_W-1:0]   idx_reg;

    // sweep
    logic [IDX_W-1:0]     cnt_reg;
    logic [CELL_BITS-1:0] fill_reg;

    // result
    logic                 m_valid_reg;
    logic [COST_W-1:0]    m_cost_reg;
    logic [IDXO_W-1:0]    m_cell_index_reg;
    logic [STAT_W-1:0]    m_status_reg;

    logic [COORD_W:0]     dx;
    logic [COORD_W:0]     dz;
    logic                 x_in;
    logic                 z_in;
    logic [LIN_W-1:0]     lin;
    logic                 lin_in;
    logic [CELL_BITS-1:0] rdata;
    logic [CELL_BITS-1:0] val_c;
    logic [CELL_BITS-1:0] unk_c;
    logic [CELL_BITS-1:0] cell_new;
    logic [COST_W-1:0]    cell_cost;
    logic [IDXO_W-1:0]    idx_out;
    logic                 wr_hit;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [CELL_BITS-1:0] ram_wdata;
    logic [CELL_BITS+COST_W-1:0] val_ext;
    logic [CELL_BITS+COST_W-1:0] unk_ext;
    logic [CELL_BITS+COST_W-1:0] cost_ext;
    logic [IDXO_W+IDX_W-1:0]     idx_ext;

    // width fitting between fields and cells
    always_comb begin
        val_ext   = {{CELL_BITS{1'b0}}, val_reg};
        val_c     = val_ext[CELL_BITS-1:0];
        unk_ext   = {{CELL_BITS{1'b0}}, cfg.unknown_cost};
        unk_c     = unk_ext[CELL_BITS-1:0];
        cost_ext  = {{COST_W{1'b0}}, rdata};
        cell_cost = cost_ext[COST_W-1:0];
        idx_ext   = {{IDXO_W{1'b0}}, idx_reg};
        idx_out   = idx_ext[IDXO_W-1:0];
    end

    // relative coordinates and bounds
    always_comb begin
        dx   = {cx_reg[COORD_W-1], cx_reg} - {cfg.origin_x[COORD_W-1], cfg.origin_x};
        dz   = {cz_reg[COORD_W-1], cz_reg} - {cfg.origin_z[COORD_W-1], cfg.origin_z};
        x_in = !dx[COORD_W] && (dx < {{(COORD_W + 1 - DIM_W){1'b0}}, cfg.grid_width});
        z_in = !dz[COORD_W] && (dz < {{(COORD_W + 1 - DIM_W){1'b0}}, cfg.grid_height});
    end

    // linear index and store bound
    always_comb begin
        lin    = {1'b0, prod_reg} + {{(LIN_W - DIM_W){1'b0}}, x_reg};
        lin_in = xz_in_reg && (lin < CELL_LIMIT);
    end

    // modified cell and store write port
    always_comb begin
        cell_new  = (op_reg == OP_SET) ? (rdata | val_c) : (rdata & ~val_c);
        wr_hit    = inside_reg && ((op_reg == OP_SET) || (op_reg == OP_CLEAR_BITS));
        ram_we    = cmd.clr_step || (cmd.do_update && wr_hit);
        ram_waddr = cmd.clr_step ? cnt_reg : idx_reg;
        ram_wdata = cmd.clr_step ? fill_reg : cell_new;
    end

    pcgs_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.do_lookup),
        .raddr (lin[IDX_W-1:0]),
        .rdata (rdata)
    );

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= s_operation;
            cx_reg  <= s_coord_x;
            cz_reg  <= s_coord_z;
            val_reg <= s_value;
        end
    end

    // calc and lookup stages
    always_ff @(posedge aclk) begin
        if (cmd.do_calc) begin
            x_reg     <= dx[DIM_W-1:0];
            prod_reg  <= dz[DIM_W-1:0] * cfg.grid_width;
            xz_in_reg <= x_in && z_in;
        end
        if (cmd.do_lookup) begin
            inside_reg <= lin_in;
            idx_reg    <= lin[IDX_W-1:0];
        end
    end

    // sweep counter and fill value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            fill_reg <= '0;
        end else if (cmd.clr_start) begin
            cnt_reg  <= '0;
            fill_reg <= unk_c;
        end else if (cmd.clr_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.do_update || cmd.load_clr_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.load_clr_result) begin
            m_cost_reg       <= '0;
            m_cell_index_reg <= '0;
            m_status_reg     <= STAT_OK;
        end else if (cmd.do_update) begin
            if (op_reg == OP_READ) begin
                if (inside_reg) begin
                    m_cost_reg       <= cell_cost;
                    m_cell_index_reg <= idx_out;
                    m_status_reg     <= STAT_OK;
                end else begin
                    m_cost_reg       <= cfg.block_cost;
                    m_cell_index_reg <= '0;
                    m_status_reg     <= STAT_READ_OUT;
                end
            end else begin
                m_cost_reg <= '0;
                if (inside_reg) begin
                    m_cell_index_reg <= idx_out;
                    m_status_reg     <= STAT_OK;
                end else begin
                    m_cell_index_reg <= '0;
                    m_status_reg     <= STAT_WRITE_OUT;
                end
            end
        end
    end

    // status to controller
    always_comb begin
        stat.item_clear_all = (s_operation == OP_CLEAR_ALL);
        stat.clr_last       = (cnt_reg == LAST_CELL);
        stat.out_free       = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_cost       = m_cost_reg;
    assign m_cell_index = m_cell_index_reg;
    assign m_status     = m_status_reg;

endmodule
`default_nettype wire

FILE: sv/packed_cost_grid_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packed_cost_grid_store
// Grid of small navigation-cost cells with read, set bits, clear bits and
// clear-all operations on absolute coordinates.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          word
//  s_        in         s_valid/s_ready    operation, coord_x, coord_z, value
//  m_        out        m_valid/m_ready    cost, cell_index, status
//  cfg_      in         cfg_we             cfg_index, cfg_data
//
//  read, set and clear-bits step through capture, multiply, index add with
//  store read, then modify and write back on the one store.
//  clear-all writes one store cell per cycle over the whole store.
//  after reset a clearing pass zeroes the store; no word is taken
//  meanwhile. a stalled result holds the last stage until m_ready.
// ----------------------------------------------------------------------------
module packed_cost_grid_store
    import pcgs_pkg::*;
#(
    parameter int CELL_BITS = CELL_BITS_DEF,
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OP_W-1:0]       s_operation,
    input  wire logic [COORD_W-1:0]    s_coord_x,
    input  wire logic [COORD_W-1:0]    s_coord_z,
    input  wire logic [COST_W-1:0]     s_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [COST_W-1:0]          m_cost,
    output logic [IDXO_W-1:0]          m_cell_index,
    output logic [STAT_W-1:0]          m_status,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    pcgs_cfg_t  cfg;
    pcgs_cmd_t  cmd;
    pcgs_stat_t stat;

    pcgs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcgs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pcgs_dp #(
        .CELL_BITS (CELL_BITS),
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .s_operation  (s_operation),
        .s_coord_x    (s_coord_x),
        .s_coord_z    (s_coord_z),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cost       (m_cost),
        .m_cell_index (m_cell_index),
        .m_status     (m_status)
    );

    // no word taken while the store is being swept
    a_no_take_in_sweep: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !s_ready
    ) else $error("input word taken during store sweep");

    // a new result never overwrites one still waiting
    a_no_result_overwrite: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (cmd.do_update || cmd.load_clr_result) |-> (!m_valid || m_ready)
    ) else $error("pending result overwritten");

    // one word in work at a time
    a_one_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("second word taken while one is in work");

    // outside positions report no cell index
    a_outside_no_index: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_OK)) |-> (m_cell_index == '0)
    ) else $error("cell index given for an outside position");

endmodule
`default_nettype wire
